@@ src/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg
// shared widths, register map, reset values and interface structs
// ----------------------------------------------------------------------------
package ttb_pkg;

  // press ring geometry
  localparam int unsigned RING_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned DVS_W      = PTR_W;

  // field widths
  localparam int unsigned TS_W      = 31;
  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned ENC_W     = 16;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned GAP_W     = 24;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned TIMEOUT_W = 31;
  localparam int unsigned MINP_W    = 7;

  // arithmetic
  localparam int unsigned ALU_W     = 34;
  localparam int unsigned DIFF_W    = ENC_W + 1;
  localparam int unsigned PROD_W    = 33;
  localparam int unsigned DIV_CNT_W = $clog2(PERIOD_W);

  // apb
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // register reset values
  localparam logic [GAP_W-1:0]     MAX_GAP_RST       = GAP_W'(1000000);
  localparam logic [STEP_W-1:0]    TEMPO_STEP_RST    = STEP_W'(250);
  localparam logic [TIMEOUT_W-1:0] PRESS_TIMEOUT_RST = TIMEOUT_W'(30000000);
  localparam logic [MINP_W-1:0]    MIN_PRESSES_RST   = MINP_W'(4);
  localparam logic [MINP_W-1:0]    MIN_NEED          = MINP_W'(2);

  typedef enum logic [1:0] {
    REG_MAX_GAP       = 2'd0,
    REG_TEMPO_STEP    = 2'd1,
    REG_PRESS_TIMEOUT = 2'd2,
    REG_MIN_PRESSES   = 2'd3
  } ttb_reg_e;

  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } ttb_alu_req_t;

  typedef struct packed {
    logic                       start;
    logic signed [PERIOD_W-1:0] dividend;
    logic [DVS_W-1:0]           divisor;
  } ttb_div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [PERIOD_W-1:0] quotient;
  } ttb_div_rsp_t;

endpackage

@@ src/ttb_ring.sv @@
// ----------------------------------------------------------------------------
// ttb_ring
// press time ring, one write and one registered read port, zero until written
// ----------------------------------------------------------------------------
module ttb_ring import ttb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  logic [TS_W-1:0]  wr_data_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output logic [TS_W-1:0]  rd_data_o
);

  logic [TS_W-1:0]       mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;
  logic [TS_W-1:0]       rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // entries never written read as zero
    rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/ttb_alu.sv @@
// ----------------------------------------------------------------------------
// ttb_alu
// shared add / subtract with saturation to the signed 32-bit range
// ----------------------------------------------------------------------------
module ttb_alu import ttb_pkg::*; (
  input  ttb_alu_req_t               req_i,
  output logic signed [PERIOD_W-1:0] sum_o
);

  logic signed [ALU_W-1:0] sum;
  logic                    fits;

  assign sum  = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
  assign fits = (sum[ALU_W-1:PERIOD_W-1] == '0) || (sum[ALU_W-1:PERIOD_W-1] == '1);

  always_comb begin
    if (fits) begin
      sum_o = sum[PERIOD_W-1:0];
    end else if (sum[ALU_W-1]) begin
      sum_o = {1'b1, {(PERIOD_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(PERIOD_W-1){1'b1}}};
    end
  end

endmodule

@@ src/ttb_div.sv @@
// ----------------------------------------------------------------------------
// ttb_div
// serial restoring divider, signed dividend by small unsigned divisor
// ----------------------------------------------------------------------------
module ttb_div import ttb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ttb_div_req_t req_i,
  output ttb_div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX,
    D_DONE
  } div_state_e;

  div_state_e           state_q, state_d;
  logic [PERIOD_W-1:0]  mag_q, mag_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 sign_q, sign_d;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       trial_sub;
  logic                 ge;

  assign trial     = {rem_q, mag_q[PERIOD_W-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    sign_d  = sign_q;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          sign_d  = req_i.dividend[PERIOD_W-1];
          mag_d   = req_i.dividend[PERIOD_W-1] ? -req_i.dividend : req_i.dividend;
          dvs_d   = req_i.divisor;
          rem_d   = '0;
          cnt_d   = DIV_CNT_W'(PERIOD_W - 1);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        // quotient bits shift in behind the dividend bits
        rem_d = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        mag_d = {mag_q[PERIOD_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = D_FIX;
        end
      end
      D_FIX: begin
        mag_d   = sign_q ? -mag_q : mag_q;
        state_d = D_DONE;
      end
      D_DONE: begin
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      mag_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      cnt_q   <= '0;
      sign_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mag_q   <= mag_d;
      rem_q   <= rem_d;
      dvs_q   <= dvs_d;
      cnt_q   <= cnt_d;
      sign_q  <= sign_d;
    end
  end

  assign rsp_o.done     = (state_q == D_DONE);
  assign rsp_o.quotient = mag_q;

endmodule

@@ src/tap_tempo_beat_generator.sv @@
// ----------------------------------------------------------------------------
// tap_tempo_beat_generator
// steps: a request without a press runs the encoder and countdown steps; a press
//   first walks the press ring, and a press that sets a new tempo also runs the
//   serial divider (ring walk one entry a cycle, then 32 steps in the serial divider)
// handshake: one request at a time; the next is taken the cycle after the result
//   is registered
// reset: all tempo state, press ring and registers return to defaults at once
// ----------------------------------------------------------------------------
module tap_tempo_beat_generator import ttb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [TS_W-1:0]            time_now_i,
  input  logic [FRAME_W-1:0]         frame_time_i,
  input  logic                       button_level_i,
  input  logic signed [ENC_W-1:0]    encoder_count_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       beat_o,
  output logic                       press_seen_o,
  output logic signed [PERIOD_W-1:0] beat_period_o
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GAP_W-1:0]     max_gap_q;
  logic [STEP_W-1:0]    tempo_step_q;
  logic [TIMEOUT_W-1:0] press_timeout_q;
  logic [MINP_W-1:0]    min_presses_q;
  ttb_reg_e             reg_sel;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = ttb_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q       <= MAX_GAP_RST;
      tempo_step_q    <= TEMPO_STEP_RST;
      press_timeout_q <= PRESS_TIMEOUT_RST;
      min_presses_q   <= MIN_PRESSES_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MAX_GAP:       max_gap_q       <= pwdata[GAP_W-1:0];
        REG_TEMPO_STEP:    tempo_step_q    <= pwdata[STEP_W-1:0];
        REG_PRESS_TIMEOUT: press_timeout_q <= pwdata[TIMEOUT_W-1:0];
        REG_MIN_PRESSES:   min_presses_q   <= pwdata[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_GAP:       prdata = APB_DATA_W'(max_gap_q);
      REG_TEMPO_STEP:    prdata = APB_DATA_W'(tempo_step_q);
      REG_PRESS_TIMEOUT: prdata = APB_DATA_W'(press_timeout_q);
      REG_MIN_PRESSES:   prdata = APB_DATA_W'(min_presses_q);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_DIV_GO,
    S_DIV,
    S_ENC_MUL,
    S_ENC_SUB,
    S_CD_SUB,
    S_CD_ADD,
    S_DONE
  } seq_state_e;

  seq_state_e                 state_q, state_d;
  // tempo state
  logic                       button_prev_q, button_prev_d;
  logic signed [ENC_W-1:0]    enc_prev_q, enc_prev_d;
  logic signed [PERIOD_W-1:0] period_q, period_d;
  logic signed [PERIOD_W-1:0] countdown_q, countdown_d;
  logic [PTR_W-1:0]           ptr_q, ptr_d;
  // per request working registers
  logic [TS_W-1:0]            now_q, now_d;
  logic [FRAME_W-1:0]         frame_q, frame_d;
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic [TS_W-1:0]            first_q, first_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [PTR_W-1:0]           idx_q, idx_d;
  logic [PTR_W-1:0]           step_q, step_d;
  logic signed [PERIOD_W-1:0] span_q, span_d;
  logic                       beat_q, beat_d;
  logic                       press_q, press_d;
  // result register
  logic                       out_valid_q, out_valid_d;
  logic                       out_beat_q, out_beat_d;
  logic                       out_press_q, out_press_d;
  logic signed [PERIOD_W-1:0] out_period_q, out_period_d;

  logic                       accept;
  logic                       rise;
  logic [PTR_W-1:0]           ptr_next;
  logic [PTR_W-1:0]           idx_prev;
  logic [TS_W-1:0]            ring_rd;
  logic                       in_group;
  logic [MINP_W-1:0]          need;
  logic signed [2*DIFF_W-1:0] mul_full;
  ttb_alu_req_t               alu_req;
  logic signed [PERIOD_W-1:0] alu_sum;
  ttb_div_req_t               div_req;
  ttb_div_rsp_t               div_rsp;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign rise       = button_level_i && !button_prev_q;

  // ring pointers wrap at any depth, not just powers of two
  assign ptr_next = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign idx_prev = (idx_q == '0) ? PTR_W'(RING_DEPTH - 1) : idx_q - 1'b1;

  // a stored press still groups when it lies within max_gap before the newer one
  assign in_group = ({1'b0, ring_rd} + 32'(max_gap_q)) >= {1'b0, first_q};

  // fewer than two presses can never give a period
  assign need = (min_presses_q < MIN_NEED) ? MIN_NEED : min_presses_q;

  assign mul_full = diff_q * $signed({1'b0, tempo_step_q});

  ttb_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && rise),
    .wr_addr_i (ptr_next),
    .wr_data_i (time_now_i),
    .rd_addr_i (idx_d),
    .rd_data_o (ring_rd)
  );

  ttb_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared adder operands by sequencer step
  always_comb begin
    alu_req.a   = {{(ALU_W-PERIOD_W){countdown_q[PERIOD_W-1]}}, countdown_q};
    alu_req.b   = {{(ALU_W-FRAME_W){1'b0}}, frame_q};
    alu_req.sub = 1'b1;
    case (state_q)
      S_CHECK: begin
        // span from the oldest grouped press to now
        alu_req.a = {{(ALU_W-TS_W){1'b0}}, now_q};
        alu_req.b = {{(ALU_W-TS_W){1'b0}}, first_q};
      end
      S_ENC_SUB: begin
        alu_req.a = {{(ALU_W-PERIOD_W){period_q[PERIOD_W-1]}}, period_q};
        alu_req.b = {{(ALU_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
      S_CD_ADD: begin
        alu_req.b   = {{(ALU_W-PERIOD_W){period_q[PERIOD_W-1]}}, period_q};
        alu_req.sub = 1'b0;
      end
      default: ;
    endcase
  end

  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = span_q;
  assign div_req.divisor  = DVS_W'(count_q - 1'b1);

  always_comb begin
    state_d       = state_q;
    button_prev_d = button_prev_q;
    enc_prev_d    = enc_prev_q;
    period_d      = period_q;
    countdown_d   = countdown_q;
    ptr_d         = ptr_q;
    now_d         = now_q;
    frame_d       = frame_q;
    diff_d        = diff_q;
    prod_d        = prod_q;
    first_d       = first_q;
    count_d       = count_q;
    idx_d         = idx_q;
    step_d        = step_q;
    span_d        = span_q;
    beat_d        = beat_q;
    press_d       = press_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_beat_d    = out_beat_q;
    out_press_d   = out_press_q;
    out_period_d  = out_period_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          now_d         = time_now_i;
          frame_d       = frame_time_i;
          diff_d        = {encoder_count_i[ENC_W-1], encoder_count_i}
                        - {enc_prev_q[ENC_W-1], enc_prev_q};
          enc_prev_d    = encoder_count_i;
          button_prev_d = button_level_i;
          beat_d        = rise;
          press_d       = rise;
          if (rise) begin
            // the new press counts itself, walk starts at the previous entry
            countdown_d = PERIOD_W'(press_timeout_q);
            ptr_d       = ptr_next;
            idx_d       = ptr_q;
            first_d     = time_now_i;
            count_d     = CNT_W'(1);
            step_d      = PTR_W'(1);
            state_d     = S_WALK;
          end else begin
            state_d = S_ENC_MUL;
          end
        end
      end
      S_WALK: begin
        // one stored press per cycle, next entry read ahead
        idx_d = idx_prev;
        if (in_group) begin
          count_d = count_q + 1'b1;
          first_d = ring_rd;
          step_d  = step_q + 1'b1;
          if (step_q == PTR_W'(RING_DEPTH - 1)) begin
            state_d = S_CHECK;
          end
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (8'(count_q) < 8'(need)) begin
          period_d = '0;
          state_d  = S_ENC_MUL;
        end else begin
          span_d      = alu_sum;
          countdown_d = '0;
          state_d     = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          period_d = div_rsp.quotient;
          state_d  = S_ENC_MUL;
        end
      end
      S_ENC_MUL: begin
        prod_d  = mul_full[PROD_W-1:0];
        state_d = S_ENC_SUB;
      end
      S_ENC_SUB: begin
        // encoder turn shifts the period and restarts the countdown
        if (diff_q != '0) begin
          period_d    = alu_sum;
          countdown_d = '0;
        end
        state_d = S_CD_SUB;
      end
      S_CD_SUB: begin
        countdown_d = alu_sum;
        state_d     = S_CD_ADD;
      end
      S_CD_ADD: begin
        if ((countdown_q <= 0) && (period_q > 0)) begin
          beat_d      = 1'b1;
          countdown_d = alu_sum;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // result register frees as soon as the previous result is taken
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_beat_d   = beat_q;
          out_press_d  = press_q;
          out_period_d = period_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      button_prev_q <= 1'b0;
      enc_prev_q    <= '0;
      period_q      <= '0;
      countdown_q   <= '0;
      ptr_q         <= '0;
      now_q         <= '0;
      frame_q       <= '0;
      diff_q        <= '0;
      prod_q        <= '0;
      first_q       <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      step_q        <= '0;
      span_q        <= '0;
      beat_q        <= 1'b0;
      press_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      out_beat_q    <= 1'b0;
      out_press_q   <= 1'b0;
      out_period_q  <= '0;
    end else begin
      state_q       <= state_d;
      button_prev_q <= button_prev_d;
      enc_prev_q    <= enc_prev_d;
      period_q      <= period_d;
      countdown_q   <= countdown_d;
      ptr_q         <= ptr_d;
      now_q         <= now_d;
      frame_q       <= frame_d;
      diff_q        <= diff_d;
      prod_q        <= prod_d;
      first_q       <= first_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      step_q        <= step_d;
      span_q        <= span_d;
      beat_q        <= beat_d;
      press_q       <= press_d;
      out_valid_q   <= out_valid_d;
      out_beat_q    <= out_beat_d;
      out_press_q   <= out_press_d;
      out_period_q  <= out_period_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign beat_o        = out_beat_q;
  assign press_seen_o  = out_press_q;
  assign beat_period_o = out_period_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait step");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (8'(count_q) <= 8'(step_q)))
    else $error("grouped press count ran ahead of the walk");

  a_press_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rise) |=> (state_q == S_WALK))
    else $error("press did not start a ring walk");

  a_press_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && press_seen_o) |-> beat_o)
    else $error("press result without a beat");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (state_q != S_DONE)) |=> !out_valid_o)
    else $error("taken result still shown");

endmodule

@@ verif/tap_tempo_beat_checker.sv @@
// ----------------------------------------------------------------------------
// tap_tempo_beat_checker
// watches the register port and both channels, predicts every beat result
// from its own copy of the tempo state and compares it with the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tap_tempo_beat_checker import ttb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [TS_W-1:0]            time_now_i,
  input  logic [FRAME_W-1:0]         frame_time_i,
  input  logic                       button_level_i,
  input  logic signed [ENC_W-1:0]    encoder_count_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       beat_i,
  input  logic                       press_seen_i,
  input  logic signed [PERIOD_W-1:0] beat_period_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic                       beat;
    logic                       press;
    logic signed [PERIOD_W-1:0] period;
  } beat_frame_t;

  // register copies
  longint      gap_lim;
  longint      step_us;
  longint      timeout_us;
  longint      need_raw;

  // tempo state
  logic        btn_last;
  longint      enc_last;
  longint      period_us;
  longint      countdown_us;
  int unsigned ring_wr;
  longint      press_times [RING_DEPTH];

  beat_frame_t frames_due [$];
  beat_frame_t due;
  int          fails;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // new press: store it, walk back through the group and derive the period
  function automatic void register_press(longint stamp);
    int unsigned idx;
    longint      hits;
    longint      oldest;
    longint      need;
    countdown_us = timeout_us;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    press_times[ring_wr] = stamp;
    idx = ring_wr;
    hits = 0;
    oldest = stamp;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (press_times[idx] < oldest - gap_lim) break;
      hits++;
      oldest = press_times[idx];
      idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
    end
    need = (need_raw < 2) ? 2 : need_raw;
    if (hits < need) begin
      period_us = 0;
      return;
    end
    period_us = clamp32((stamp - oldest) / (hits - 1));
    countdown_us = 0;
  endfunction

  function automatic beat_frame_t step_frame(longint stamp, longint frame, logic level,
                                             longint enc);
    beat_frame_t r;
    longint      delta;
    r.beat  = 1'b0;
    r.press = 1'b0;
    if (level) begin
      if (!btn_last) begin
        btn_last = 1'b1;
        r.beat   = 1'b1;
        r.press  = 1'b1;
        register_press(stamp);
      end
    end else begin
      btn_last = 1'b0;
    end
    delta = enc - enc_last;
    if (delta != 0) begin
      period_us    = clamp32(period_us - delta * step_us);
      enc_last     = enc;
      countdown_us = 0;
    end
    countdown_us = clamp32(countdown_us - frame);
    if (countdown_us <= 0 && period_us > 0) begin
      r.beat       = 1'b1;
      countdown_us = clamp32(countdown_us + period_us);
    end
    r.period = period_us[PERIOD_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_lim      = MAX_GAP_RST;
      step_us      = TEMPO_STEP_RST;
      timeout_us   = PRESS_TIMEOUT_RST;
      need_raw     = MIN_PRESSES_RST;
      btn_last     = 1'b0;
      enc_last     = 0;
      period_us    = 0;
      countdown_us = 0;
      ring_wr      = 0;
      for (int i = 0; i < RING_DEPTH; i++) press_times[i] = 0;
      frames_due.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ttb_reg_e'(paddr[APB_ADDR_W-1:2]))
          REG_MAX_GAP:       gap_lim    = pwdata[GAP_W-1:0];
          REG_TEMPO_STEP:    step_us    = pwdata[STEP_W-1:0];
          REG_PRESS_TIMEOUT: timeout_us = pwdata[TIMEOUT_W-1:0];
          REG_MIN_PRESSES:   need_raw   = pwdata[MINP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          fails++;
          $display("%0t: unrequested result: beat %0b press %0b period %0d",
                   $time, beat_i, press_seen_i, beat_period_i);
        end else begin
          due = frames_due.pop_front();
          if (beat_i !== due.beat) begin
            fails++;
            $display("%0t: beat: expected %0b, actual %0b", $time, due.beat, beat_i);
          end
          if (press_seen_i !== due.press) begin
            fails++;
            $display("%0t: press_seen: expected %0b, actual %0b",
                     $time, due.press, press_seen_i);
          end
          if (beat_period_i !== due.period) begin
            fails++;
            $display("%0t: beat_period: expected %0d, actual %0d",
                     $time, due.period, beat_period_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        frames_due.push_back(step_frame(time_now_i, frame_time_i, button_level_i,
                                        encoder_count_i));
      pending_o    <= frames_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ verif/tap_tempo_beat_generator_tb.sv @@
// ----------------------------------------------------------------------------
// tap_tempo_beat_generator_tb
// drives frame requests and register settings into the beat generator; a
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tap_tempo_beat_generator_tb;
  import ttb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES = 64;    // covers the longest tempo latency
  localparam int unsigned PHASE_FRAMES = 75;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr           = '0;
  logic [APB_DATA_W-1:0]      pwdata          = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [TS_W-1:0]            time_now_i      = '0;
  logic [FRAME_W-1:0]         frame_time_i    = '0;
  logic                       button_level_i  = 1'b0;
  logic signed [ENC_W-1:0]    encoder_count_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic                       beat_o;
  logic                       press_seen_o;
  logic signed [PERIOD_W-1:0] beat_period_o;

  int                         fail_count;
  int                         pending;
  int unsigned                quiet_cycles    = 0;
  int unsigned                frames_sent     = 0;

  // idling policy, reshuffled per burst of stimulus
  bit                         sender_gaps     = 1'b0;
  bit                         stall_on        = 1'b0;
  bit                         late_run        = 1'b0;

  // stimulus-side view of time, encoder and the current setting
  logic [TS_W-1:0]            clock_us        = TS_W'(1000);
  logic signed [ENC_W-1:0]    enc_pos         = '0;
  longint                     gap_cfg         = MAX_GAP_RST;

  tap_tempo_beat_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .time_now_i      (time_now_i),
    .frame_time_i    (frame_time_i),
    .button_level_i  (button_level_i),
    .encoder_count_i (encoder_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .beat_o          (beat_o),
    .press_seen_o    (press_seen_o),
    .beat_period_o   (beat_period_o)
  );

  tap_tempo_beat_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .time_now_i      (time_now_i),
    .frame_time_i    (frame_time_i),
    .button_level_i  (button_level_i),
    .encoder_count_i (encoder_count_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .beat_i          (beat_o),
    .press_seen_i    (press_seen_o),
    .beat_period_i   (beat_period_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // watchdog: any request, result or register access counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tap_tempo_beat_generator verification failed");
      $finish;
    end
  end

  // result side back-pressure in short random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // back-to-back apb writes; the caller closes the transfer
  task automatic write_reg(ttb_reg_e which, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // one frame request, held until the block takes it
  task automatic send_frame(logic [TS_W-1:0] stamp, logic [FRAME_W-1:0] frame,
                            logic level, logic signed [ENC_W-1:0] enc);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    time_now_i      <= stamp;
    frame_time_i    <= frame;
    button_level_i  <= level;
    encoder_count_i <= enc;
    do @(posedge clk_i); while (in_stall_o);
    frames_sent++;
  endtask

  // frame on the running timeline
  task automatic play_frame(logic [FRAME_W-1:0] frame, logic level);
    clock_us = clock_us + TS_W'(frame);
    send_frame(clock_us, frame, level, enc_pos);
  endtask

  // wait until every request has its result back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [GAP_W-1:0] gap, logic [STEP_W-1:0] step,
                               logic [TIMEOUT_W-1:0] timeout, logic [MINP_W-1:0] minp);
    settle();
    write_reg(REG_MAX_GAP, APB_DATA_W'(gap));
    write_reg(REG_TEMPO_STEP, APB_DATA_W'(step));
    write_reg(REG_PRESS_TIMEOUT, APB_DATA_W'(timeout));
    write_reg(REG_MIN_PRESSES, APB_DATA_W'(minp));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gap_cfg  = gap;
  endtask

  // a run of taps, mostly inside the grouping gap, some beyond it
  task automatic tap_burst();
    int unsigned taps;
    int unsigned parts;
    longint      interval;
    taps = $urandom_range(2, 10);
    for (int t = 0; t < taps; t++) begin
      if ($urandom_range(0, 5) == 0)
        interval = gap_cfg + $urandom_range(1, 5000);
      else
        interval = $urandom_range(0, int'(gap_cfg));
      parts = $urandom_range(2, 4);
      if ($urandom_range(0, 7) == 0)
        enc_pos = enc_pos + ENC_W'($urandom_range(0, 4)) - ENC_W'(2);
      if ($urandom_range(0, 9) == 0)
        // press stamped off the timeline, usually out of order
        send_frame(TS_W'($urandom), FRAME_W'($urandom_range(0, 2000)), 1'b1, enc_pos);
      else
        play_frame(FRAME_W'($urandom_range(0, 2000)), 1'b1);
      for (int p = 0; p < parts; p++)
        play_frame(FRAME_W'(interval / parts), 1'b0);
    end
  endtask

  // encoder turns, mostly steps of up to three detents either way, sometimes a jump anywhere
  task automatic turn_encoder();
    int unsigned steps;
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      if ($urandom_range(0, 5) == 0)
        enc_pos = ENC_W'($urandom);
      else
        enc_pos = enc_pos + ENC_W'($urandom_range(0, 6)) - ENC_W'(3);
      play_frame(FRAME_W'($urandom_range(0, 40000)), 1'b0);
    end
  endtask

  task automatic noise_frame();
    if ($urandom_range(0, 1) == 0)
      clock_us = TS_W'($urandom);
    enc_pos = ENC_W'($urandom);
    send_frame(TS_W'($urandom), FRAME_W'($urandom), 1'($urandom), enc_pos);
  endtask

  task automatic run_mix(int unsigned quota);
    int unsigned mark;
    mark = frames_sent;
    while (frames_sent - mark < quota) begin
      // some stretches run without any idling
      sender_gaps = !late_run && $urandom_range(0, 2) != 0;
      stall_on    = !late_run && $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: tap_burst();
        5, 6:          turn_encoder();
        7: begin
          repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 2) == 0)
              play_frame(FRAME_W'($urandom), 1'b0);
            else
              play_frame(FRAME_W'($urandom_range(0, 20000)), 1'b0);
          end
        end
        default: noise_frame();
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset settings
    send_frame(TS_W'(0), FRAME_W'(0), 1'b0, ENC_W'(0));
    // first press: the cleared ring entries still lie within the gap
    send_frame(TS_W'(100), FRAME_W'(100), 1'b1, ENC_W'(0));
    send_frame(TS_W'(150), FRAME_W'(50), 1'b0, ENC_W'(0));
    send_frame(TS_W'(600), FRAME_W'(450), 1'b1, ENC_W'(0));
    send_frame(TS_W'(610), FRAME_W'(10), 1'b0, ENC_W'(0));
    // far-future press, then a press stamped before it
    send_frame({TS_W{1'b1}}, {FRAME_W{1'b1}}, 1'b1, ENC_W'(0));
    send_frame({TS_W{1'b1}}, FRAME_W'(0), 1'b0, ENC_W'(0));
    send_frame(TS_W'(7), FRAME_W'(0), 1'b1, ENC_W'(0));
    // held button with encoder extremes
    send_frame(TS_W'(8), {FRAME_W{1'b1}}, 1'b1, 16'sh7FFF);
    send_frame(TS_W'(9), FRAME_W'(1), 1'b0, 16'sh8000);
    send_frame(TS_W'(10), FRAME_W'(1), 1'b0, 16'sh0000);
    send_frame(TS_W'(11), FRAME_W'(24'h800000), 1'b0, 16'shFFFF);
    send_frame(TS_W'(12), FRAME_W'(24'h7FFFFF), 1'b0, 16'sh0001);
    // steady 500 ms taps, enough to lock a tempo
    clock_us = TS_W'(40000000);
    enc_pos  = 16'sh0001;
    repeat (5) begin
      play_frame(FRAME_W'(1000), 1'b1);
      play_frame(FRAME_W'(499000), 1'b0);
    end

    apply_setting(GAP_W'(1000000), STEP_W'(250), TIMEOUT_W'(30000000), MINP_W'(2));
    run_mix(PHASE_FRAMES);

    // widest gap and largest step: encoder swings hit the period limits
    apply_setting({GAP_W{1'b1}}, {STEP_W{1'b1}}, {TIMEOUT_W{1'b1}}, MINP_W'(0));
    enc_pos = 16'sh7FFF;
    play_frame(FRAME_W'(10), 1'b0);
    enc_pos = 16'sh8000;
    play_frame(FRAME_W'(10), 1'b0);
    enc_pos = 16'sh7FFF;
    play_frame(FRAME_W'(10), 1'b0);
    enc_pos = 16'sh8000;
    play_frame(FRAME_W'(10), 1'b0);
    run_mix(PHASE_FRAMES);

    apply_setting(GAP_W'(1), STEP_W'(0), TIMEOUT_W'(0), MINP_W'(1));
    run_mix(PHASE_FRAMES);

    apply_setting(GAP_W'(50000), STEP_W'(1), TIMEOUT_W'(12345), MINP_W'(8));
    run_mix(PHASE_FRAMES);

    // more presses than the ring holds: never a tempo
    apply_setting(GAP_W'(300000), STEP_W'(4000), TIMEOUT_W'(700000), MINP_W'(9));
    run_mix(PHASE_FRAMES);

    // press clears the period, then maximal frames drive the countdown into its floor
    apply_setting(GAP_W'($urandom_range(1, 24'hFFFFFF)), STEP_W'($urandom),
                  TIMEOUT_W'(0), {MINP_W{1'b1}});
    play_frame(FRAME_W'(0), 1'b0);
    play_frame(FRAME_W'(0), 1'b1);
    repeat (140) play_frame({FRAME_W{1'b1}}, 1'b0);
    run_mix(30);

    // closing stretch with no idling on either side
    apply_setting(GAP_W'(200000), STEP_W'(500), TIMEOUT_W'(5000000), MINP_W'(3));
    late_run = 1'b1;
    run_mix(PHASE_FRAMES);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tap_tempo_beat_generator verification clean");
    else
      $display("tap_tempo_beat_generator verification failed");
    $finish;
  end

endmodule
